// ===== hw/rtl/lbps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbps_pkg: shared types and constants of the LED and buzzer pattern sequencer
// Item payload structs, command, target, pattern and status codes, and the
// step periods of the blink patterns in milliseconds.
// ----------------------------------------------------------------------------
package lbps_pkg;

   localparam int TIME_BITS_DEFAULT = 24;
   localparam int DURATION_BITS     = 24;
   localparam int PERIOD_BITS       = 11;

   // Item commands.
   localparam logic [1:0] MODE_TICK  = 2'd0;
   localparam logic [1:0] MODE_START = 2'd1;
   localparam logic [1:0] MODE_STOP  = 2'd2;

   // Addressed outputs.
   localparam logic [1:0] TARGET_LED    = 2'd0;
   localparam logic [1:0] TARGET_BUZZER = 2'd1;
   localparam logic [1:0] TARGET_BOTH   = 2'd2;

   // Pattern codes.
   localparam logic [2:0] PAT_OFF       = 3'd0;
   localparam logic [2:0] PAT_ON        = 3'd1;
   localparam logic [2:0] PAT_SLOW      = 3'd2;
   localparam logic [2:0] PAT_FAST      = 3'd3;
   localparam logic [2:0] PAT_PULSE     = 3'd4;
   localparam logic [2:0] PAT_HEARTBEAT = 3'd5;
   localparam logic [2:0] PAT_SOS       = 3'd6;

   // Result status codes.
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_IGNORED  = 2'd1;
   localparam logic [1:0] STATUS_BAD_PAT  = 2'd2;

   // Register indexes.
   localparam logic REG_MUTE     = 1'b0;
   localparam logic REG_OVERRIDE = 1'b1;

   // Step periods in milliseconds.
   localparam logic [PERIOD_BITS-1:0] PERIOD_SLOW  = 11'd1000;
   localparam logic [PERIOD_BITS-1:0] PERIOD_FAST  = 11'd250;
   localparam logic [PERIOD_BITS-1:0] PERIOD_SHORT = 11'd100;
   localparam logic [PERIOD_BITS-1:0] PERIOD_SOS   = 11'd200;

   typedef struct packed {
      logic [1:0]               mode;
      logic [1:0]               target;
      logic [2:0]               pattern;
      logic [1:0]               priority_req;
      logic [DURATION_BITS-1:0] duration;
   } req_payload_type;

   typedef struct packed {
      logic       led;
      logic       buzzer;
      logic       active;
      logic [1:0] status;
      logic [2:0] shown_pattern;
      logic [1:0] shown_priority;
   } rsp_payload_type;

endpackage

// ===== hw/rtl/led_buzzer_pattern_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_buzzer_pattern_sequencer: prioritized LED and buzzer indication engine
// Runs steady, blink, pulse and heartbeat indications from 1 ms tick items,
// with priority arbitration between start requests and optional durations.
// ----------------------------------------------------------------------------
// Usage:
// The req channel carries one item per millisecond tick, start request or
// stop request. Every accepted item produces exactly one result item on the
// rsp channel, holding the LED and buzzer drive levels after the item, the
// active flag, a status code and the pattern and priority being shown.
// The result of an item accepted at one clock edge is registered and is valid
// in the cycle after it. Throughput is one item per cycle while the receiver
// takes the results; the whole update is a few counter increments and compares
// between the state registers and the result register, so nothing iterates.
// If the receiver stalls, the result register holds its item and req_ready
// stays high only while that register is empty or being drained in the same
// cycle, so a new item can enter while the previous result is taken.
// After reset all indications are off, no result is pending, the step period
// is the short period and both registers (mute, override_enable) read zero.
// The APB registers lie at byte addresses 0 (mute) and 4 (override_enable); the
// user must see they are written only while the block is idle (not enforced).
// ----------------------------------------------------------------------------
module led_buzzer_pattern_sequencer
   import lbps_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data,
   input  logic            psel,
   input  logic            penable,
   input  logic            pwrite,
   input  logic [2:0]      paddr,
   input  logic [31:0]     pwdata,
   output logic [31:0]     prdata,
   output logic            pready
);

   // Largest time value, computed one bit wider than any supported width.
   localparam logic [32:0] TimeMaxWide = (33'd1 << TIME_BITS) - 33'd1;
   localparam logic [TIME_BITS-1:0] TimeMax = TimeMaxWide[TIME_BITS-1:0];

   // Configuration registers.
   logic mute_ff, mute_in;
   logic override_ff, override_in;

   // Indication state.
   logic                   led_ff, led_in;
   logic                   buzzer_ff, buzzer_in;
   logic                   active_ff, active_in;
   logic                   running_ff, running_in;
   logic [2:0]             pattern_ff, pattern_in;
   logic [1:0]             target_ff, target_in;
   logic [1:0]             priority_ff, priority_in;
   logic [TIME_BITS-1:0]   run_length_ff, run_length_in;
   logic [TIME_BITS-1:0]   elapsed_ff, elapsed_in;
   logic [PERIOD_BITS-1:0] period_ff, period_in;
   logic [PERIOD_BITS-1:0] count_ff, count_in;
   logic [1:0]             phase_ff, phase_in;

   // Result register.
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   logic                 req_accept;
   logic                 cfg_write;
   logic                 clear_ind;
   logic                 hit_led;
   logic                 hit_buzzer;
   logic [1:0]           status;
   logic [1:0]           stop_target;
   logic [32:0]          duration_wide;
   logic [TIME_BITS-1:0] duration_sat;

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;
   assign cfg_write  = psel && penable && pwrite;
   assign pready     = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   always_comb begin
      case (paddr[2])
         REG_MUTE:     prdata = {31'd0, mute_ff};
         REG_OVERRIDE: prdata = {31'd0, override_ff};
         default:      prdata = 32'd0;
      endcase
   end

   // A duration longer than the time counters can hold saturates.
   assign duration_wide = {{(33 - DURATION_BITS){1'b0}}, req_data.duration};
   assign duration_sat  = (duration_wide > TimeMaxWide) ? TimeMax
                                                        : duration_wide[TIME_BITS-1:0];

   // The update is written in the order the events happen within one item:
   // configuration first, then the item, each step reading what the one
   // before it left behind.
   always_comb begin
      mute_in       = mute_ff;
      override_in   = override_ff;
      led_in        = led_ff;
      buzzer_in     = buzzer_ff;
      active_in     = active_ff;
      running_in    = running_ff;
      pattern_in    = pattern_ff;
      target_in     = target_ff;
      priority_in   = priority_ff;
      run_length_in = run_length_ff;
      elapsed_in    = elapsed_ff;
      period_in     = period_ff;
      count_in      = count_ff;
      phase_in      = phase_ff;
      status        = STATUS_OK;
      stop_target   = req_data.target;
      clear_ind     = 1'b0;
      hit_led       = 1'b0;
      hit_buzzer    = 1'b0;

      if (cfg_write) begin
         case (paddr[2])
            REG_MUTE: begin
               mute_in = pwdata[0];
               if (pwdata[0]) begin
                  buzzer_in = 1'b0;
               end
            end
            REG_OVERRIDE: override_in = pwdata[0];
            default: ;
         endcase
      end

      if (req_accept) begin
         case (req_data.mode)
            MODE_TICK: begin
               // The duration check comes first and ends the item when it fires.
               if (active_in) begin
                  if (elapsed_in != TimeMax) begin
                     elapsed_in = elapsed_in + 1'b1;
                  end
                  if (run_length_in != '0 && elapsed_in >= run_length_in) begin
                     clear_ind   = 1'b1;
                     stop_target = target_in;
                  end
               end
               if (!clear_ind && running_in) begin
                  count_in = count_in + 1'b1;
                  if (count_in >= period_in) begin
                     count_in = '0;
                     if (active_in) begin
                        case (pattern_in)
                           PAT_SLOW, PAT_FAST: begin
                              led_in = !led_in;
                              if (target_in == TARGET_BOTH) begin
                                 buzzer_in = led_in && !mute_in ? 1'b1 :
                                             (led_in ? buzzer_in : 1'b0);
                              end
                              period_in = (pattern_in == PAT_SLOW) ? PERIOD_SLOW
                                                                    : PERIOD_FAST;
                           end
                           PAT_PULSE: begin
                              led_in    = !led_in;
                              period_in = PERIOD_SHORT;
                           end
                           PAT_HEARTBEAT: begin
                              led_in    = (phase_in == 2'd0 || phase_in == 2'd2);
                              period_in = (phase_in == 2'd3) ? PERIOD_SLOW
                                                             : PERIOD_SHORT;
                              phase_in  = phase_in + 2'd1;
                           end
                           default: ;
                        endcase
                     end
                  end
               end
               if (clear_ind) begin
                  // Ending on duration stops the outputs of the active target.
                  running_in = 1'b0;
                  if (stop_target == TARGET_LED || stop_target == TARGET_BOTH) begin
                     led_in = 1'b0;
                  end
                  if (stop_target == TARGET_BUZZER || stop_target == TARGET_BOTH) begin
                     buzzer_in = 1'b0;
                  end
                  active_in     = 1'b0;
                  pattern_in    = PAT_OFF;
                  target_in     = TARGET_LED;
                  priority_in   = 2'd0;
                  run_length_in = '0;
                  elapsed_in    = '0;
               end
            end

            MODE_START: begin
               if (active_in && !override_in && req_data.priority_req < priority_in) begin
                  status = STATUS_IGNORED;
               end else begin
                  // The old indication always goes away completely.
                  running_in    = 1'b0;
                  led_in        = 1'b0;
                  buzzer_in     = 1'b0;
                  active_in     = 1'b1;
                  pattern_in    = req_data.pattern;
                  target_in     = req_data.target;
                  priority_in   = req_data.priority_req;
                  run_length_in = duration_sat;
                  elapsed_in    = '0;
                  hit_led    = (req_data.target == TARGET_LED ||
                                req_data.target == TARGET_BOTH);
                  hit_buzzer = (req_data.target == TARGET_BUZZER ||
                                req_data.target == TARGET_BOTH);
                  case (req_data.pattern)
                     PAT_OFF: begin
                        active_in     = 1'b0;
                        pattern_in    = PAT_OFF;
                        target_in     = TARGET_LED;
                        priority_in   = 2'd0;
                        run_length_in = '0;
                     end
                     PAT_ON, PAT_SOS: begin
                        led_in    = hit_led;
                        buzzer_in = hit_buzzer && !mute_in;
                        if (req_data.pattern == PAT_SOS) begin
                           period_in  = PERIOD_SOS;
                           count_in   = '0;
                           running_in = 1'b1;
                        end
                     end
                     PAT_SLOW, PAT_FAST, PAT_PULSE, PAT_HEARTBEAT: begin
                        count_in   = '0;
                        running_in = 1'b1;
                     end
                     default: begin
                        // An invalid pattern is recorded but drives nothing.
                        run_length_in = '0;
                        status        = STATUS_BAD_PAT;
                     end
                  endcase
               end
            end

            MODE_STOP: begin
               running_in = 1'b0;
               if (stop_target == TARGET_LED || stop_target == TARGET_BOTH) begin
                  led_in = 1'b0;
               end
               if (stop_target == TARGET_BUZZER || stop_target == TARGET_BOTH) begin
                  buzzer_in = 1'b0;
               end
               // A stop for some other target leaves the indication marked active.
               if (stop_target == target_in || stop_target == TARGET_BOTH) begin
                  active_in     = 1'b0;
                  pattern_in    = PAT_OFF;
                  target_in     = TARGET_LED;
                  priority_in   = 2'd0;
                  run_length_in = '0;
                  elapsed_in    = '0;
               end
            end

            default: ;
         endcase
      end

      rsp_data_in.led            = led_in;
      rsp_data_in.buzzer         = buzzer_in;
      rsp_data_in.active         = active_in;
      rsp_data_in.status         = status;
      rsp_data_in.shown_pattern  = pattern_in;
      rsp_data_in.shown_priority = priority_in;

      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mute_ff       <= 1'b0;
         override_ff   <= 1'b0;
         led_ff        <= 1'b0;
         buzzer_ff     <= 1'b0;
         active_ff     <= 1'b0;
         running_ff    <= 1'b0;
         pattern_ff    <= PAT_OFF;
         target_ff     <= TARGET_LED;
         priority_ff   <= 2'd0;
         run_length_ff <= '0;
         elapsed_ff    <= '0;
         period_ff     <= PERIOD_SHORT;
         count_ff      <= '0;
         phase_ff      <= 2'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         mute_ff       <= mute_in;
         override_ff   <= override_in;
         led_ff        <= led_in;
         buzzer_ff     <= buzzer_in;
         active_ff     <= active_in;
         running_ff    <= running_in;
         pattern_ff    <= pattern_in;
         target_ff     <= target_in;
         priority_ff   <= priority_in;
         run_length_ff <= run_length_in;
         elapsed_ff    <= elapsed_in;
         period_ff     <= period_in;
         count_ff      <= count_in;
         phase_ff      <= phase_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // The result payload needs no reset; it is qualified by rsp_valid.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// ===== test/tb_led_buzzer_pattern_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_led_buzzer_pattern_sequencer: self-checking bench for the pattern sequencer
// Drives tick, start and stop items through the req channel and predicts
// every result item with a cycle-free model of the sequencer state. Runs
// directed corner cases, tick runs for the blink timing, a long receiver
// hold and random traffic under several idling mixes and register settings.
// ----------------------------------------------------------------------------
module tb_led_buzzer_pattern_sequencer;
   import lbps_pkg::*;

   // Codes with no name in the package: the unused command, the target that
   // addresses neither output and the invalid pattern.
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam logic [1:0] TARGET_NONE = 2'd3;
   localparam logic [2:0] PAT_INVALID = 3'd7;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int HOLD_CYCLES  = 300;
   localparam int SETTLE_TICKS = 4;
   localparam int MAX_PRINTS   = 100;

   // ------------------------------------------------------------------------
   // Block ports. Every input has a known value from time zero.
   // ------------------------------------------------------------------------
   logic            clock;
   logic            reset     = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_data  = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_data;
   logic            psel      = 1'b0;
   logic            penable   = 1'b0;
   logic            pwrite    = 1'b0;
   logic [2:0]      paddr     = '0;
   logic [31:0]     pwdata    = '0;
   logic [31:0]     prdata;
   logic            pready;

   led_buzzer_pattern_sequencer DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Bench bookkeeping.
   // ------------------------------------------------------------------------
   rsp_payload_type expected_results[$];
   int              error_count   = 0;
   int              results_seen  = 0;
   int              cycle_count   = 0;
   int              sender_idle_pct    = 0;
   int              receiver_stall_pct = 0;
   logic            hold_active = 1'b0;
   event            hold_off_ev;

   // ------------------------------------------------------------------------
   // Predicted sequencer state. The configuration copies live here too, so a
   // register write updates the prediction in the same place as the block.
   // ------------------------------------------------------------------------
   logic        cfg_mute;
   logic        cfg_override;
   logic        led_q;
   logic        buzz_q;
   logic        busy_q;
   logic        stepping_q;
   logic [2:0]  cur_pattern;
   logic [1:0]  cur_target;
   logic [1:0]  cur_priority;
   logic [23:0] limit_ms;
   logic [23:0] age_ms;
   logic [10:0] period_ms;
   logic [10:0] step_ms;
   logic [1:0]  beat_phase;

   function automatic void clear_sequencer();
      cfg_mute     = 1'b0;
      cfg_override = 1'b0;
      led_q        = 1'b0;
      buzz_q       = 1'b0;
      busy_q       = 1'b0;
      stepping_q   = 1'b0;
      cur_pattern  = PAT_OFF;
      cur_target   = TARGET_LED;
      cur_priority = 2'd0;
      limit_ms     = '0;
      age_ms       = '0;
      period_ms    = PERIOD_SHORT;
      step_ms      = '0;
      beat_phase   = 2'd0;
   endfunction

   // Any buzzer turn-on is swallowed while muted.
   function automatic void buzz_unless_muted();
      if (!cfg_mute)
         buzz_q = 1'b1;
   endfunction

   // Stops the step timer and drops the addressed outputs. The indication
   // itself is only cleared when the stop covers its own target or both.
   function automatic void halt_outputs(input logic [1:0] tgt);
      stepping_q = 1'b0;
      if (tgt == TARGET_LED || tgt == TARGET_BOTH)
         led_q = 1'b0;
      if (tgt == TARGET_BUZZER || tgt == TARGET_BOTH)
         buzz_q = 1'b0;
      if (tgt == cur_target || tgt == TARGET_BOTH) begin
         busy_q       = 1'b0;
         cur_pattern  = PAT_OFF;
         cur_target   = TARGET_LED;
         cur_priority = 2'd0;
         limit_ms     = '0;
         age_ms       = '0;
      end
   endfunction

   function automatic void buzzer_follows_led();
      if (cur_target == TARGET_BOTH) begin
         if (led_q)
            buzz_unless_muted();
         else
            buzz_q = 1'b0;
      end
   endfunction

   function automatic void fire_step();
      if (!busy_q)
         return;
      case (cur_pattern)
         PAT_SLOW: begin
            led_q = ~led_q;
            buzzer_follows_led();
            period_ms = PERIOD_SLOW;
         end
         PAT_FAST: begin
            led_q = ~led_q;
            buzzer_follows_led();
            period_ms = PERIOD_FAST;
         end
         PAT_PULSE: begin
            led_q = ~led_q;
            period_ms = PERIOD_SHORT;
         end
         PAT_HEARTBEAT: begin
            led_q      = (beat_phase == 2'd0 || beat_phase == 2'd2);
            period_ms  = (beat_phase == 2'd3) ? PERIOD_SLOW : PERIOD_SHORT;
            beat_phase = beat_phase + 2'd1;
         end
         default: ;
      endcase
   endfunction

   // One millisecond: age the indication, end it on its duration, then step
   // the blink timer. The age saturates rather than wrapping.
   function automatic void advance_ms();
      if (busy_q) begin
         if (age_ms != '1)
            age_ms = age_ms + 24'd1;
         if (limit_ms != '0 && age_ms >= limit_ms) begin
            halt_outputs(cur_target);
            return;
         end
      end
      if (stepping_q) begin
         step_ms = step_ms + 11'd1;
         if (step_ms >= period_ms) begin
            step_ms = '0;
            fire_step();
         end
      end
   endfunction

   // The duration field is exactly as wide as the time counters here, so it
   // never needs clamping.
   function automatic logic [1:0] begin_indication(input req_payload_type r);
      logic [1:0] outcome;
      outcome = STATUS_OK;
      if (busy_q && !cfg_override && r.priority_req < cur_priority)
         return STATUS_IGNORED;
      halt_outputs(TARGET_BOTH);
      cur_pattern  = r.pattern;
      cur_target   = r.target;
      cur_priority = r.priority_req;
      limit_ms     = r.duration;
      age_ms       = '0;
      busy_q       = 1'b1;
      case (r.pattern)
         PAT_OFF: halt_outputs(TARGET_BOTH);
         PAT_ON, PAT_SOS: begin
            if (r.target == TARGET_LED || r.target == TARGET_BOTH)
               led_q = 1'b1;
            if (r.target == TARGET_BUZZER || r.target == TARGET_BOTH)
               buzz_unless_muted();
            if (r.pattern == PAT_SOS) begin
               period_ms  = PERIOD_SOS;
               step_ms    = '0;
               stepping_q = 1'b1;
            end
         end
         PAT_SLOW, PAT_FAST, PAT_PULSE, PAT_HEARTBEAT: begin
            step_ms    = '0;
            stepping_q = 1'b1;
         end
         default: begin
            limit_ms = '0;
            outcome  = STATUS_BAD_PAT;
         end
      endcase
      return outcome;
   endfunction

   function automatic rsp_payload_type predict_result(input req_payload_type r);
      rsp_payload_type res;
      logic [1:0]      outcome;
      outcome = STATUS_OK;
      case (r.mode)
         MODE_TICK:  advance_ms();
         MODE_START: outcome = begin_indication(r);
         MODE_STOP:  halt_outputs(r.target);
         default: ;
      endcase
      res.led            = led_q;
      res.buzzer         = buzz_q;
      res.active         = busy_q;
      res.status         = outcome;
      res.shown_pattern  = cur_pattern;
      res.shown_priority = cur_priority;
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // Result checking. Both channels are sampled at the falling edge, where
   // everything driven or registered at the rising edge has settled; a
   // valid/ready pair seen there is the handshake of the next rising edge.
   // ------------------------------------------------------------------------
   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= MAX_PRINTS)
         $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   task automatic check_field(input string name, input logic [2:0] got,
                              input logic [2:0] want);
      if (got !== want)
         report_mismatch($sformatf("result %0d field %s: got %0d, expected %0d",
                                   results_seen, name, got, want));
   endtask

   always @(negedge clock) begin : result_check
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with no item outstanding",
                                      results_seen));
         end else begin
            want = expected_results.pop_front();
            check_field("led", 3'(rsp_data.led), 3'(want.led));
            check_field("buzzer", 3'(rsp_data.buzzer), 3'(want.buzzer));
            check_field("active", 3'(rsp_data.active), 3'(want.active));
            check_field("status", 3'(rsp_data.status), 3'(want.status));
            check_field("shown_pattern", rsp_data.shown_pattern, want.shown_pattern);
            check_field("shown_priority", 3'(rsp_data.shown_priority),
                        3'(want.shown_priority));
         end
         results_seen++;
      end
   end

   // ------------------------------------------------------------------------
   // Receiver side. Ready is redrawn every cycle from the current stall rate,
   // unless a long hold is in progress. The hold counts its own cycles so the
   // sender can keep offering items and fill the block up.
   // ------------------------------------------------------------------------
   always @(posedge clock)
      rsp_ready <= !hold_active && ($urandom_range(99) >= receiver_stall_pct);

   initial begin : receiver_hold
      forever begin
         @(hold_off_ev);
         @(negedge clock);
         hold_active = 1'b1;
         repeat (HOLD_CYCLES) @(negedge clock);
         hold_active = 1'b0;
      end
   end

   // A hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Sender side and register access. Every task is entered and left at a
   // rising edge, and each of them makes at most one assignment per signal
   // in any time step.
   // ------------------------------------------------------------------------
   function automatic req_payload_type make_item(input logic [1:0] mode,
                                                 input logic [1:0] tgt,
                                                 input logic [2:0] pat,
                                                 input logic [1:0] pri,
                                                 input logic [23:0] dur);
      req_payload_type r;
      r.mode         = mode;
      r.target       = tgt;
      r.pattern      = pat;
      r.priority_req = pri;
      r.duration     = dur;
      return r;
   endfunction

   // A tick ignores every other field, so they carry random bits.
   function automatic req_payload_type tick_item();
      return make_item(MODE_TICK, 2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                       2'($urandom_range(0, 3)), 24'($urandom));
   endfunction

   // Durations lean toward short runs that actually expire, with the whole
   // field range and both extremes mixed in.
   function automatic logic [23:0] pick_duration();
      int pick;
      pick = $urandom_range(99);
      if (pick < 40)
         return '0;
      if (pick < 80)
         return 24'($urandom_range(1, 150));
      if (pick < 90)
         return 24'($urandom_range(151, 2000));
      if (pick < 96)
         return 24'($urandom);
      return '1;
   endfunction

   function automatic req_payload_type random_start();
      return make_item(MODE_START, 2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                       2'($urandom_range(0, 3)), pick_duration());
   endfunction

   function automatic req_payload_type random_stop();
      return make_item(MODE_STOP, 2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                       2'($urandom_range(0, 3)), 24'($urandom));
   endfunction

   // Valid is lowered only when an idle gap follows, so a back-to-back item
   // just swaps the payload under a valid that stays high.
   task automatic send_item(input req_payload_type item);
      int gap;
      gap = 0;
      while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do
         @(negedge clock);
      while (!req_ready);
      @(posedge clock);
      expected_results.push_back(predict_result(item));
   endtask

   task automatic send_ticks(input int count);
      repeat (count) send_item(tick_item());
   endtask

   // Waits until every outstanding result is in, then lets the block settle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic write_csr(input logic reg_idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (reg_idx == REG_MUTE) begin
         cfg_mute = value[0];
         if (cfg_mute)
            buzz_q = 1'b0;
      end else begin
         cfg_override = value[0];
      end
   endtask

   task automatic set_idling(input int idle_pct, input int stall_pct);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
   endtask

   // ------------------------------------------------------------------------
   // Tests.
   // ------------------------------------------------------------------------

   // Corner cases from an idle block with mute and override both off.
   task automatic test_directed_cases();
      // An idle tick and the unused command must change nothing.
      send_item(make_item(MODE_TICK, TARGET_LED, PAT_OFF, 2'd0, '0));
      send_item(make_item(MODE_UNUSED, TARGET_NONE, PAT_INVALID, 2'd3, '1));
      // Steady on for the LED; a buzzer request replaces it and the LED drops.
      send_item(make_item(MODE_START, TARGET_LED, PAT_ON, 2'd0, '0));
      send_item(make_item(MODE_START, TARGET_BUZZER, PAT_ON, 2'd1, '0));
      // SOS is held as steady on; a lower priority request is then refused.
      send_item(make_item(MODE_START, TARGET_BOTH, PAT_SOS, 2'd3, '1));
      send_item(make_item(MODE_START, TARGET_LED, PAT_FAST, 2'd0, 24'd10));
      // Stops that miss the active target only drop outputs and the timer.
      send_item(make_item(MODE_STOP, TARGET_LED, PAT_OFF, 2'd0, '0));
      send_item(make_item(MODE_STOP, TARGET_BUZZER, PAT_OFF, 2'd0, '0));
      send_item(make_item(MODE_STOP, TARGET_NONE, PAT_OFF, 2'd0, '0));
      send_item(make_item(MODE_STOP, TARGET_BOTH, PAT_OFF, 2'd0, '0));
      // An invalid pattern stays active with no outputs and its duration
      // thrown away, so the ticks after it must not end it.
      send_item(make_item(MODE_START, TARGET_BUZZER, PAT_INVALID, 2'd2, 24'd2));
      send_ticks(3);
      // Pattern off clears the indication at once.
      send_item(make_item(MODE_START, TARGET_LED, PAT_OFF, 2'd2, '0));
      // A start addressing no output; only a stop with that same target or
      // with both clears it.
      send_item(make_item(MODE_START, TARGET_NONE, PAT_ON, 2'd1, '0));
      send_item(make_item(MODE_STOP, TARGET_LED, PAT_OFF, 2'd0, '0));
      send_item(make_item(MODE_STOP, TARGET_NONE, PAT_OFF, 2'd0, '0));
      // A two millisecond pulse on the buzzer alone ends by its duration.
      send_item(make_item(MODE_START, TARGET_BUZZER, PAT_PULSE, 2'd0, 24'd2));
      send_ticks(3);
   endtask

   // Tick runs long enough for the first steps of each pattern to fire. A
   // new pattern keeps the step period left by the one before until its own
   // first step. Critical priority makes each start win over whatever ran
   // before.
   task automatic test_blink_timing();
      // Pulse toggles the LED even though only the buzzer is addressed.
      send_item(make_item(MODE_START, TARGET_BUZZER, PAT_PULSE, 2'd3, '0));
      send_ticks(220);
      // Heartbeat runs through its first short steps.
      send_item(make_item(MODE_START, TARGET_BOTH, PAT_HEARTBEAT, 2'd3, '0));
      send_ticks(220);
      // Slow blink with the buzzer following, cut off by its duration.
      send_item(make_item(MODE_START, TARGET_BOTH, PAT_SLOW, 2'd3, 24'd150));
      send_ticks(160);
      // The SOS timer restarts on its own period but never changes an output.
      send_item(make_item(MODE_START, TARGET_LED, PAT_SOS, 2'd3, '0));
      send_ticks(20);
      send_item(make_item(MODE_START, TARGET_BOTH, PAT_FAST, 2'd3, '0));
      send_ticks(210);
   endtask

   // The receiver stops for a long stretch while items keep coming, so the
   // result register fills and req_ready must fall.
   task automatic test_receiver_hold();
      -> hold_off_ev;
      send_item(make_item(MODE_START, TARGET_BOTH, PAT_PULSE, 2'd3, 24'd150));
      send_ticks(40);
      repeat (20) send_item(random_start());
      send_ticks(20);
   endtask

   // Leaves the buzzer on so that the following mute write has to drop it.
   task automatic test_mute_drops_buzzer();
      send_item(make_item(MODE_START, TARGET_BOTH, PAT_ON, 2'd3, '0));
      wait_idle();
      write_csr(REG_MUTE, 32'd1);
      send_ticks(2);
   endtask

   // While muted the buzzer neither follows the LED nor turns on directly.
   task automatic test_muted_blink();
      send_item(make_item(MODE_START, TARGET_BOTH, PAT_FAST, 2'd3, '0));
      send_ticks(120);
      send_item(make_item(MODE_START, TARGET_BUZZER, PAT_ON, 2'd3, 24'd5));
      send_ticks(6);
   endtask

   // With override on, a low priority start replaces a critical one.
   task automatic test_override_replaces();
      send_item(make_item(MODE_START, TARGET_BOTH, PAT_ON, 2'd3, '0));
      send_item(make_item(MODE_START, TARGET_LED, PAT_FAST, 2'd0, '0));
      send_item(make_item(MODE_START, TARGET_BUZZER, PAT_SLOW, 2'd1, 24'd8));
      send_ticks(10);
   endtask

   // Mostly start requests followed by a run of ticks and sometimes a stop,
   // with lone starts, lone stops and fully random items as noise.
   task automatic run_random_traffic(input int budget);
      int sent;
      int kind;
      int run_len;
      sent = 0;
      while (sent < budget) begin
         kind = $urandom_range(99);
         if (kind < 60) begin
            send_item(random_start());
            run_len = ($urandom_range(19) == 0) ? $urandom_range(150, 500)
                                                : $urandom_range(0, 40);
            send_ticks(run_len);
            sent += 1 + run_len;
            if ($urandom_range(2) == 0) begin
               send_item(random_stop());
               sent++;
            end
         end else if (kind < 78) begin
            send_item(random_start());
            sent++;
         end else if (kind < 88) begin
            send_item(random_stop());
            sent++;
         end else begin
            send_item(make_item(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                                3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
                                24'($urandom)));
            sent++;
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Run order. Register settings change only once every result is in: between
   // phases and once inside the mute test.
   // ------------------------------------------------------------------------
   initial begin
      clear_sequencer();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Phase one: no idling, mute and override off.
      set_idling(0, 0);
      write_csr(REG_MUTE, 32'd0);
      write_csr(REG_OVERRIDE, 32'd0);
      test_directed_cases();
      test_blink_timing();
      test_receiver_hold();
      run_random_traffic(100);
      test_mute_drops_buzzer();

      // Phase two: the sender idles most of the time, buzzer muted.
      wait_idle();
      set_idling(85, 0);
      test_muted_blink();
      run_random_traffic(100);

      // Phase three: the receiver stalls most of the time, override on.
      wait_idle();
      write_csr(REG_MUTE, 32'd0);
      write_csr(REG_OVERRIDE, 32'd1);
      set_idling(0, 85);
      test_override_replaces();
      run_random_traffic(100);

      // Phase four: both sides idle now and then, mute and override on.
      wait_idle();
      write_csr(REG_MUTE, 32'd1);
      set_idling(32, 32);
      run_random_traffic(100);

      wait_idle();
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== led_buzzer_pattern_sequencer.f =====
hw/rtl/lbps_pkg.sv
hw/rtl/led_buzzer_pattern_sequencer.sv
test/tb_led_buzzer_pattern_sequencer.sv
